### rtl/pcd_pkg.sv
// Shared types and constants for the periodic central difference block.
package pcd_pkg;

    // Field widths of the stream payloads
    localparam int SAMPLE_W    = 32;
    localparam int ROW_IDX_W   = 12;
    localparam int COL_IDX_W   = 10;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 56;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_STEP = 2'd2;

    // Reset values of the registers
    localparam int          ROWS_RST = 64;
    localparam int          COLS_RST = 64;
    localparam logic [31:0] INV_RST  = 32'h0001_0000;

    // Saturation limits of a Q16.16 result
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // Result beat selector within one item
    localparam logic [1:0] BEAT_PREV = 2'd0;
    localparam logic [1:0] BEAT_CUR  = 2'd1;
    localparam logic [1:0] BEAT_WRAP = 2'd2;

    // Load strobes for the arithmetic stages
    typedef struct packed {
        logic ld_diff;
        logic ld_prod;
        logic ld_part;
    } pcd_stage_en_t;

    // Per-item tags that travel beside the arithmetic
    typedef struct packed {
        logic [ROW_IDX_W-1:0] row_prev;
        logic [ROW_IDX_W-1:0] row_cur;
        logic [COL_IDX_W-1:0] col;
        logic                 triple;
    } pcd_meta_t;

endpackage

### rtl/pcd_deriv_lane.sv
// One arithmetic lane: coef * (a - b) * inv_two_step / 2^32, floored and saturated.
module pcd_deriv_lane
    import pcd_pkg::*;
(
    input  logic                        aclk,
    input  pcd_stage_en_t               stage_en,
    input  logic signed [SAMPLE_W-1:0]  minuend,
    input  logic signed [SAMPLE_W-1:0]  subtrahend,
    input  logic signed [SAMPLE_W-1:0]  coef,
    input  logic [SAMPLE_W-1:0]         inv_two_step,
    output logic signed [SAMPLE_W-1:0]  result
);

    logic signed [32:0] diff_next;
    logic signed [32:0] diff_reg;
    logic signed [31:0] coef_reg;
    logic signed [64:0] prod_full;
    logic signed [63:0] prod_next;
    logic signed [63:0] prod_reg;
    logic signed [31:0] prod_hi;
    logic signed [32:0] inv_signed;
    logic signed [64:0] part_hi_full;
    logic signed [63:0] part_hi_next;
    logic signed [63:0] part_hi_reg;
    logic [63:0]        part_lo_next;
    logic [63:0]        part_lo_reg;
    logic signed [64:0] sum;
    logic               pos_ovf;
    logic               neg_ovf;

    // Stage 2: exact 33-bit difference
    assign diff_next = 33'(minuend) - 33'(subtrahend);

    always_ff @(posedge aclk) begin
        if (stage_en.ld_diff) begin
            diff_reg <= diff_next;
            coef_reg <= coef;
        end
    end

    // Stage 3: coef * diff, magnitude stays below 2^63
    assign prod_full = 65'(coef_reg) * 65'(diff_reg);
    assign prod_next = prod_full[63:0];

    always_ff @(posedge aclk) begin
        if (stage_en.ld_prod) begin
            prod_reg <= prod_next;
        end
    end

    // Stage 4: split product by 32 bits, two partial products against inv
    assign prod_hi      = prod_reg[63:32];
    assign inv_signed   = {1'b0, inv_two_step};
    assign part_hi_full = 65'(prod_hi) * 65'(inv_signed);
    assign part_hi_next = part_hi_full[63:0];
    assign part_lo_next = 64'(prod_reg[31:0]) * 64'(inv_two_step);

    always_ff @(posedge aclk) begin
        if (stage_en.ld_part) begin
            part_hi_reg <= part_hi_next;
            part_lo_reg <= part_lo_next;
        end
    end

    // Floor of the full product over 2^32, then clamp to 32 bits
    assign sum     = {part_hi_reg[63], part_hi_reg} + {33'b0, part_lo_reg[63:32]};
    assign pos_ovf = !sum[64] && (|sum[63:31]);
    assign neg_ovf = sum[64] && !(&sum[63:31]);

    always_comb begin
        if (pos_ovf) begin
            result = SAT_MAX;
        end else if (neg_ovf) begin
            result = SAT_MIN;
        end else begin
            result = sum[31:0];
        end
    end

endmodule

### rtl/periodic_central_difference.sv
// Periodic central difference along rows of a streamed grid, Q16.16 fixed point.
//
// Input stream (s_*): one grid sample per beat in row-major order, with the
// coefficient of its column. Result stream (m_*): derivative values tagged with
// row and column; tlast marks the final result caused by one input beat.
// Rows 0 and 1 produce no results; rows 2 .. R-2 give one result for the row
// above; the last row gives three results (rows R-2, R-1 and 0 of that column).
// Configuration is written through cfg_wr_* while the block is idle; writing the
// row or column count restarts the frame at row 0, column 0.
// Path: a result passes the memory read, difference, product and partial-product
// stages, then the output register.
// Throughput: one input beat per cycle while m_tready is high; on the last row the output
// register holds each input until its three results leave through the single result port.
// Each pipeline stage carries a valid bit and stalls only when the stage after it
// is full, so a stalled receiver fills the bubbles before s_tready drops.
// Reset (aresetn low, synchronous) empties the pipeline, returns the frame to
// row 0, column 0 and restores the register defaults. Line buffer contents are
// not cleared; each entry is written before a frame reads it.
module periodic_central_difference
    import pcd_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input beats
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,    // [31:0] sample, [63:32] coef
    // Result beats
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,    // [11:0] row_index, [21:12] col_index,
                                               // [53:22] value, [55:54] zero
    output logic                   m_tlast,
    // Configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int RPOS_W = $clog2(MAX_ROWS);
    localparam int CPOS_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROWS_RST_CLAMP = (ROWS_RST > MAX_ROWS) ? MAX_ROWS : ROWS_RST;
    localparam int COLS_RST_CLAMP = (COLS_RST > MAX_COLS) ? MAX_COLS : COLS_RST;
    localparam logic [RPOS_W-1:0] ROWS_LAST_RST = RPOS_W'(ROWS_RST_CLAMP - 1);
    localparam logic [CPOS_W-1:0] COLS_LAST_RST = CPOS_W'(COLS_RST_CLAMP - 1);

    // Configuration and frame position
    logic [RPOS_W-1:0]   rows_last_reg;
    logic [RPOS_W-1:0]   rows_last_next;
    logic [CPOS_W-1:0]   cols_last_reg;
    logic [CPOS_W-1:0]   cols_last_next;
    logic [31:0]         inv_reg;
    logic [31:0]         rows_req;
    logic [31:0]         rows_clamped;
    logic [31:0]         cols_req;
    logic [31:0]         cols_clamped;
    logic [RPOS_W-1:0]   row_pos_reg;
    logic [CPOS_W-1:0]   col_pos_reg;
    logic                frame_restart;

    // Input beat fields
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [SAMPLE_W-1:0] in_coef;
    logic                       in_accept;

    // Line buffers
    logic [SAMPLE_W-1:0] even_mem   [MAX_COLS];
    logic [SAMPLE_W-1:0] odd_mem    [MAX_COLS];
    logic [SAMPLE_W-1:0] first_mem  [MAX_COLS];
    logic [SAMPLE_W-1:0] second_mem [MAX_COLS];
    logic [SAMPLE_W-1:0] even_rd_reg;
    logic [SAMPLE_W-1:0] odd_rd_reg;
    logic [SAMPLE_W-1:0] first_rd_reg;
    logic [SAMPLE_W-1:0] second_rd_reg;

    // Pipeline stages
    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    pcd_meta_t                  s1_meta_reg, s2_meta_reg, s3_meta_reg, s4_meta_reg;
    pcd_meta_t                  s1_meta_next;
    logic                       s1_parity_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic signed [SAMPLE_W-1:0] s1_coef_reg;
    logic                       ready_1, ready_2, ready_3, ready_4, ready_e;
    pcd_stage_en_t              stage_en;

    // Lane operands and results
    logic signed [SAMPLE_W-1:0] older_val;
    logic signed [SAMPLE_W-1:0] newer_val;
    logic signed [SAMPLE_W-1:0] lane_val [3];

    // Output register
    logic                       e_valid_reg;
    pcd_meta_t                  e_meta_reg;
    logic [SAMPLE_W-1:0]        e_val_reg [3];
    logic [1:0]                 e_idx_reg;
    logic                       e_last;
    logic [ROW_IDX_W-1:0]       out_row;

    assign in_sample = s_tdata[31:0];
    assign in_coef   = s_tdata[63:32];
    assign in_accept = s_tvalid && s_tready;

    // Clamp the size registers as they are written
    always_comb begin
        rows_req       = 32'(cfg_wr_data[12:0]);
        cols_req       = 32'(cfg_wr_data[10:0]);
        rows_clamped   = (rows_req < 32'd3) ? 32'd3 :
                         ((rows_req > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : rows_req);
        cols_clamped   = (cols_req < 32'd1) ? 32'd1 :
                         ((cols_req > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cols_req);
        rows_last_next = RPOS_W'(rows_clamped - 32'd1);
        cols_last_next = CPOS_W'(cols_clamped - 32'd1);
    end

    assign frame_restart = cfg_wr_en &&
                           (cfg_wr_index == REG_ROWS_IN_USE ||
                            cfg_wr_index == REG_COLS_IN_USE);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_last_reg <= ROWS_LAST_RST;
            cols_last_reg <= COLS_LAST_RST;
            inv_reg       <= INV_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_ROWS_IN_USE:  rows_last_reg <= rows_last_next;
                REG_COLS_IN_USE:  cols_last_reg <= cols_last_next;
                REG_INV_TWO_STEP: inv_reg       <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Frame position: column runs fastest, rows wrap at the configured count
    always_ff @(posedge aclk) begin
        if (!aresetn || frame_restart) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end else if (in_accept) begin
            if (col_pos_reg == cols_last_reg) begin
                col_pos_reg <= '0;
                row_pos_reg <= (row_pos_reg == rows_last_reg) ? '0 : row_pos_reg + 1'b1;
            end else begin
                col_pos_reg <= col_pos_reg + 1'b1;
            end
        end
    end

    // Rolling rows by parity: a row overwrites the row two above it, read first
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            even_rd_reg <= even_mem[col_pos_reg];
            if (!row_pos_reg[0]) begin
                even_mem[col_pos_reg] <= in_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            odd_rd_reg <= odd_mem[col_pos_reg];
            if (row_pos_reg[0]) begin
                odd_mem[col_pos_reg] <= in_sample;
            end
        end
    end

    // Rows 0 and 1 kept for the wrap at the last row
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            first_rd_reg <= first_mem[col_pos_reg];
            if (row_pos_reg == RPOS_W'(0)) begin
                first_mem[col_pos_reg] <= in_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            second_rd_reg <= second_mem[col_pos_reg];
            if (row_pos_reg == RPOS_W'(1)) begin
                second_mem[col_pos_reg] <= in_sample;
            end
        end
    end

    // Stage handshake: a stage loads when it is empty or its successor loads
    assign ready_e  = !e_valid_reg || (m_tready && e_last);
    assign ready_4  = !s4_valid_reg || ready_e;
    assign ready_3  = !s3_valid_reg || ready_4;
    assign ready_2  = !s2_valid_reg || ready_3;
    assign ready_1  = !s1_valid_reg || ready_2;
    assign s_tready = ready_1;

    assign stage_en.ld_diff = ready_2;
    assign stage_en.ld_prod = ready_3;
    assign stage_en.ld_part = ready_4;

    // Tags of the accepted beat
    always_comb begin
        s1_meta_next.row_prev = ROW_IDX_W'(row_pos_reg - 1'b1);
        s1_meta_next.row_cur  = ROW_IDX_W'(row_pos_reg);
        s1_meta_next.col      = COL_IDX_W'(col_pos_reg);
        s1_meta_next.triple   = (row_pos_reg == rows_last_reg);
    end

    // Stage 1: only rows from 2 on cause results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (ready_1) begin
            s1_valid_reg <= in_accept && (row_pos_reg >= RPOS_W'(2));
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_meta_reg   <= s1_meta_next;
            s1_parity_reg <= row_pos_reg[0];
            s1_sample_reg <= in_sample;
            s1_coef_reg   <= in_coef;
        end
    end

    // Stages 2 to 4: valid bits and tags beside the lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (ready_2) s2_valid_reg <= s1_valid_reg;
            if (ready_3) s3_valid_reg <= s2_valid_reg;
            if (ready_4) s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_2) s2_meta_reg <= s1_meta_reg;
        if (ready_3) s3_meta_reg <= s2_meta_reg;
        if (ready_4) s4_meta_reg <= s3_meta_reg;
    end

    // Row r-2 shares the parity of row r, row r-1 has the other
    assign older_val = s1_parity_reg ? odd_rd_reg : even_rd_reg;
    assign newer_val = s1_parity_reg ? even_rd_reg : odd_rd_reg;

    // Result for row r-1
    pcd_deriv_lane u_lane_prev (
        .aclk         (aclk),
        .stage_en     (stage_en),
        .minuend      (s1_sample_reg),
        .subtrahend   (older_val),
        .coef         (s1_coef_reg),
        .inv_two_step (inv_reg),
        .result       (lane_val[0])
    );

    // Result for the last row, wrapping to row 0
    pcd_deriv_lane u_lane_cur (
        .aclk         (aclk),
        .stage_en     (stage_en),
        .minuend      (first_rd_reg),
        .subtrahend   (newer_val),
        .coef         (s1_coef_reg),
        .inv_two_step (inv_reg),
        .result       (lane_val[1])
    );

    // Result for row 0, from row 1 and the last row
    pcd_deriv_lane u_lane_wrap (
        .aclk         (aclk),
        .stage_en     (stage_en),
        .minuend      (second_rd_reg),
        .subtrahend   (s1_sample_reg),
        .coef         (s1_coef_reg),
        .inv_two_step (inv_reg),
        .result       (lane_val[2])
    );

    // Output register: one beat, or three on the last row
    assign e_last = !e_meta_reg.triple || (e_idx_reg == BEAT_WRAP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            e_idx_reg   <= BEAT_PREV;
        end else if (ready_e) begin
            e_valid_reg <= s4_valid_reg;
            e_idx_reg   <= BEAT_PREV;
        end else if (m_tready) begin
            e_idx_reg   <= e_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_e) begin
            e_meta_reg   <= s4_meta_reg;
            e_val_reg[0] <= lane_val[0];
            e_val_reg[1] <= lane_val[1];
            e_val_reg[2] <= lane_val[2];
        end
    end

    // Row tag of the current beat
    always_comb begin
        case (e_idx_reg)
            BEAT_PREV: out_row = e_meta_reg.row_prev;
            BEAT_CUR:  out_row = e_meta_reg.row_cur;
            default:   out_row = '0;
        endcase
    end

    assign m_tvalid = e_valid_reg;
    assign m_tlast  = e_last;
    assign m_tdata  = {2'b00, e_val_reg[e_idx_reg], e_meta_reg.col, out_row};

    // A multi-beat item keeps the output busy until its final beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("result beats of one item were cut short");

    // Only last-row items step past the first beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        e_valid_reg && !e_meta_reg.triple |-> e_idx_reg == BEAT_PREV)
        else $error("beat index moved on a single-result item");

    // Frame position stays inside the configured grid
    assert property (@(posedge aclk) disable iff (!aresetn)
        row_pos_reg <= rows_last_reg && col_pos_reg <= cols_last_reg)
        else $error("frame position outside the grid");

    // A size write restarts the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_restart |=> row_pos_reg == '0 && col_pos_reg == '0)
        else $error("size write did not restart the frame");

    // Input stalls only when the first stage holds a waiting item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && s2_valid_reg)
        else $error("input stalled with room in the pipeline");

endmodule
